>>> src/mcma_pkg.sv
`timescale 1ns / 1ps

package mcma_pkg;

    localparam int CHANNEL_BITS        = 3;
    localparam int CHANNELS_DEFAULT    = 4;
    localparam int WINDOW_DEFAULT      = 5;
    localparam int SAMPLE_BITS_DEFAULT = 16;

endpackage

>>> src/mcma_if.sv
`timescale 1ns / 1ps

interface mcma_in_if #(
    parameter int SAMPLE_BITS = mcma_pkg::SAMPLE_BITS_DEFAULT
);
    import mcma_pkg::*;

    logic                           valid;
    logic                           ready;
    logic        [CHANNEL_BITS-1:0] channel;
    logic signed [SAMPLE_BITS-1:0]  sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink (input valid, input channel, input sample, output ready);
endinterface

interface mcma_out_if #(
    parameter int SAMPLE_BITS = mcma_pkg::SAMPLE_BITS_DEFAULT
);
    import mcma_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] average;
    logic                          passed_through;

    modport source (output valid, output average, output passed_through, input ready);
    modport sink (input valid, input average, input passed_through, output ready);
endinterface

>>> src/multichannel_moving_average.sv
`timescale 1ns / 1ps

// path: update (single per-channel read-modify-write), divide, output register
// throughput: one transfer per cycle while result ready allows, set by the update stage
// reset: clears all stage valids, write positions, wrap flags and channel primed flags
// the window memory is not cleared; entries are read only after priming covers them

module multichannel_moving_average #(
    parameter int CHANNELS    = mcma_pkg::CHANNELS_DEFAULT,
    parameter int WINDOW      = mcma_pkg::WINDOW_DEFAULT,
    parameter int SAMPLE_BITS = mcma_pkg::SAMPLE_BITS_DEFAULT
) (
    input logic        clk,
    input logic        rst_n,
    mcma_in_if.sink    sample_ch,
    mcma_out_if.source result_ch
);
    import mcma_pkg::*;

    localparam int SB       = SAMPLE_BITS;
    localparam int SUMW     = SAMPLE_BITS + $clog2(WINDOW);
    localparam int CIDX     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POSW     = $clog2(WINDOW);
    localparam int DEPTH    = CHANNELS * WINDOW;
    localparam int ADDRW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [POSW-1:0] POS_LAST = POSW'(WINDOW - 1);

    // per-channel state
    logic [POSW-1:0]        pos_reg     [CHANNELS];
    logic                   primed_reg  [CHANNELS];
    logic                   wrapped_reg [CHANNELS];
    logic signed [SB-1:0]   first_reg   [CHANNELS];
    logic signed [SUMW-1:0] sum_reg     [CHANNELS];
    logic [SB-1:0]          win_mem     [DEPTH];

    // stage registers
    logic                    s1_valid_reg;
    logic [CHANNEL_BITS-1:0] s1_ch_reg;
    logic signed [SB-1:0]    s1_sample_reg;
    logic [SB-1:0]           s1_old_reg;
    logic                    s2_valid_reg;
    logic signed [SUMW-1:0]  s2_sum_reg;
    logic signed [SB-1:0]    s2_sample_reg;
    logic                    s2_pass_reg;
    logic                    out_valid_reg;
    logic signed [SB-1:0]    out_avg_reg;
    logic                    out_pass_reg;

    logic                    out_adv;
    logic                    s2_open;
    logic                    s1_adv;
    logic                    in_ready;
    logic                    in_accept;

    logic                    in_range;
    logic [CIDX-1:0]         in_idx;
    logic [POSW-1:0]         rd_pos;
    logic [ADDRW-1:0]        rd_addr;

    logic                    s1_range;
    logic [CIDX-1:0]         s1_idx;
    logic                    s1_primed;
    logic [POSW-1:0]         s1_pos;
    logic [POSW-1:0]         s1_pos_nxt;
    logic signed [SUMW-1:0]  s1_x_ext;
    logic signed [SUMW-1:0]  s1_old_ext;
    logic signed [SUMW-1:0]  s1_sum_upd;
    logic signed [SUMW-1:0]  s1_sum_first;
    logic [ADDRW-1:0]        wr_addr;
    logic                    s1_update;
    logic                    wr_en;

    logic signed [SB-1:0]    div_q;

    // flow control
    always_comb
    begin
        out_adv   = !out_valid_reg || result_ch.ready;
        s2_open   = !s2_valid_reg || out_adv;
        s1_adv    = s1_valid_reg && s2_open;
        in_ready  = !s1_valid_reg || s2_open;
        in_accept = sample_ch.valid && in_ready;
    end

    assign sample_ch.ready         = in_ready;
    assign result_ch.valid         = out_valid_reg;
    assign result_ch.average       = out_avg_reg;
    assign result_ch.passed_through = out_pass_reg;

    // update stage
    always_comb
    begin
        s1_range     = ({1'b0, s1_ch_reg} < (CHANNEL_BITS + 1)'(CHANNELS));
        s1_idx       = s1_ch_reg[CIDX-1:0];
        s1_primed    = primed_reg[s1_idx];
        s1_pos       = pos_reg[s1_idx];
        s1_pos_nxt   = (s1_pos == POS_LAST) ? '0 : s1_pos + POSW'(1);
        s1_x_ext     = {{(SUMW - SB){s1_sample_reg[SB-1]}}, s1_sample_reg};
        s1_old_ext   = wrapped_reg[s1_idx]
                     ? {{(SUMW - SB){s1_old_reg[SB-1]}}, s1_old_reg}
                     : {{(SUMW - SB){first_reg[s1_idx][SB-1]}}, first_reg[s1_idx]};
        s1_sum_upd   = sum_reg[s1_idx] - s1_old_ext + s1_x_ext;
        s1_sum_first = s1_x_ext * $signed(SUMW'(WINDOW));
        s1_update    = s1_adv && s1_range;
        wr_en        = s1_update && s1_primed;
        wr_addr      = ADDRW'(int'(s1_idx) * WINDOW + int'(s1_pos));
    end

    // read address, forwarded from the item leaving the update stage
    always_comb
    begin
        in_range = ({1'b0, sample_ch.channel} < (CHANNEL_BITS + 1)'(CHANNELS));
        in_idx   = sample_ch.channel[CIDX-1:0];
        if (s1_update && (s1_idx == in_idx))
        begin
            rd_pos = s1_primed ? s1_pos_nxt : '0;
        end
        else
        begin
            rd_pos = pos_reg[in_idx];
        end
        rd_addr = ADDRW'(int'(in_idx) * WINDOW + int'(rd_pos));
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            win_mem[wr_addr] <= s1_sample_reg;
        end
        if (in_accept && in_range)
        begin
            s1_old_reg <= win_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                pos_reg[i]     <= '0;
                primed_reg[i]  <= 1'b0;
                wrapped_reg[i] <= 1'b0;
            end
        end
        else if (s1_update)
        begin
            if (!s1_primed)
            begin
                primed_reg[s1_idx]  <= 1'b1;
                wrapped_reg[s1_idx] <= 1'b0;
                pos_reg[s1_idx]     <= '0;
            end
            else
            begin
                pos_reg[s1_idx] <= s1_pos_nxt;
                if (s1_pos == POS_LAST)
                begin
                    wrapped_reg[s1_idx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_update)
        begin
            if (!s1_primed)
            begin
                first_reg[s1_idx] <= s1_sample_reg;
                sum_reg[s1_idx]   <= s1_sum_first;
            end
            else
            begin
                sum_reg[s1_idx] <= s1_sum_upd;
            end
        end
    end

    mcma_div #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUMW)
    ) u_div (
        .dividend (s2_sum_reg),
        .quotient (div_q)
    );

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= sample_ch.valid;
            end
            if (s2_open)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_ch_reg     <= sample_ch.channel;
            s1_sample_reg <= sample_ch.sample;
        end
        if (s1_adv)
        begin
            s2_sum_reg    <= s1_sum_upd;
            s2_sample_reg <= s1_sample_reg;
            s2_pass_reg   <= !s1_range || !s1_primed;
        end
        if (out_adv && s2_valid_reg)
        begin
            out_avg_reg  <= s2_pass_reg ? s2_sample_reg : div_q;
            out_pass_reg <= s2_pass_reg;
        end
    end

endmodule

>>> src/mcma_div.sv
`timescale 1ns / 1ps

module mcma_div #(
    parameter int WINDOW      = mcma_pkg::WINDOW_DEFAULT,
    parameter int SAMPLE_BITS = mcma_pkg::SAMPLE_BITS_DEFAULT,
    parameter int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW)
) (
    input  logic signed [SUM_BITS-1:0]    dividend,
    output logic signed [SAMPLE_BITS-1:0] quotient
);
    localparam logic [SUM_BITS-1:0] RECIP   = SUM_BITS'((64'd1 << SUM_BITS) / WINDOW);
    localparam logic [SUM_BITS-1:0] DIVISOR = SUM_BITS'(WINDOW);

    logic                    neg;
    logic [SUM_BITS-1:0]     mag;
    logic [2*SUM_BITS-1:0]   prod;
    logic [SUM_BITS-1:0]     q_est;
    logic [SUM_BITS-1:0]     rem;
    logic [SUM_BITS-1:0]     q_fix;
    logic [SUM_BITS-1:0]     q_signed;

    // reciprocal estimate is low by at most one, fixed by one compare
    always_comb
    begin
        neg      = dividend[SUM_BITS-1];
        mag      = neg ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);
        prod     = {{SUM_BITS{1'b0}}, mag} * {{SUM_BITS{1'b0}}, RECIP};
        q_est    = prod[2*SUM_BITS-1:SUM_BITS];
        rem      = mag - SUM_BITS'(q_est * DIVISOR);
        q_fix    = (rem >= DIVISOR) ? q_est + SUM_BITS'(1) : q_est;
        q_signed = neg ? SUM_BITS'(-q_fix) : q_fix;
        quotient = q_signed[SAMPLE_BITS-1:0];
    end

endmodule

>>> tb/sv/tb_multichannel_moving_average.sv
`timescale 1ns / 1ps

module tb_multichannel_moving_average;

    import mcma_pkg::*;

    localparam int CHANNELS    = CHANNELS_DEFAULT;
    localparam int WINDOW      = WINDOW_DEFAULT;
    localparam int SAMPLE_BITS = SAMPLE_BITS_DEFAULT;
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW);
    localparam int MAX_SHOWN   = 50;

    typedef logic        [CHANNEL_BITS-1:0] chan_t;
    typedef logic signed [SAMPLE_BITS-1:0]  sample_t;
    typedef logic signed [SUM_BITS-1:0]     sum_t;

    typedef struct {
        sample_t average;
        logic    passed_through;
    } avg_result_t;

    logic clk;
    logic rst_n;

    mcma_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) sample_if ();
    mcma_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_if ();

    multichannel_moving_average #(
        .CHANNELS    (CHANNELS),
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_if),
        .result_ch (result_if)
    );

    // filter state mirrored in the testbench
    sample_t     hist_window [CHANNELS][WINDOW];
    sum_t        hist_sum    [CHANNELS];
    int unsigned hist_pos    [CHANNELS];
    logic        hist_primed [CHANNELS];

    avg_result_t expected_averages[$];

    int  error_count;
    int  in_transfers;
    int  results_checked;
    int  out_of_range_count;
    int  priming_count;
    bit  tx_idle_en;
    bit  rx_stall_en;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", expected_averages.size());
        $display("tb_multichannel_moving_average: FAIL");
        $finish;
    end

    function automatic avg_result_t filter_sample(input chan_t ch, input sample_t smp);
        avg_result_t res;
        int          c;
        int unsigned p;
        res.average        = smp;
        res.passed_through = 1'b1;
        if (ch >= CHANNELS)
        begin
            out_of_range_count++;
            return res;
        end
        c = int'(ch);
        if (!hist_primed[c])
        begin
            for (int j = 0; j < WINDOW; j++)
            begin
                hist_window[c][j] = smp;
            end
            hist_sum[c]    = sum_t'(sum_t'(smp) * WINDOW);
            hist_pos[c]    = 0;
            hist_primed[c] = 1'b1;
            priming_count++;
            return res;
        end
        p = hist_pos[c];
        hist_sum[c]       = hist_sum[c] - sum_t'(hist_window[c][p]) + sum_t'(smp);
        hist_window[c][p] = smp;
        hist_pos[c]       = (p + 1 >= WINDOW) ? 0 : p + 1;
        res.average        = sample_t'(hist_sum[c] / WINDOW);
        res.passed_through = 1'b0;
        return res;
    endfunction

    task automatic report(input string what, input int got, input int want);
        if (error_count < MAX_SHOWN)
        begin
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        end
        error_count++;
    endtask

    // input side: predict on every accepted transfer
    always @(posedge clk)
    begin
        if (rst_n && sample_if.valid && sample_if.ready)
        begin
            expected_averages.push_back(filter_sample(sample_if.channel, sample_if.sample));
            in_transfers++;
        end
    end

    // output side: compare against the oldest prediction
    always @(posedge clk)
    begin
        avg_result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_averages.size() == 0)
            begin
                report("unexpected result average", int'(result_if.average), 0);
            end
            else
            begin
                want = expected_averages.pop_front();
                results_checked++;
                if (result_if.average !== want.average)
                begin
                    report("average", int'(result_if.average), int'(want.average));
                end
                if (result_if.passed_through !== want.passed_through)
                begin
                    report("passed_through", int'(result_if.passed_through),
                           int'(want.passed_through));
                end
            end
        end
    end

    // receiver backpressure
    initial
    begin
        int stall_left;
        int r;
        stall_left = 0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rx_stall_en)
            begin
                result_if.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                result_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    result_if.ready <= 1'b1;
                end
                else if (r < 92)
                begin
                    result_if.ready <= 1'b0;
                    stall_left = $urandom_range(0, 3);
                end
                else
                begin
                    result_if.ready <= 1'b0;
                    stall_left = $urandom_range(10, 40);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (!tx_idle_en)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic sample_t pick_sample();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return sample_t'(32767);
            1:       return sample_t'(-32768);
            2, 3:    return sample_t'(int'($urandom_range(0, 64)) - 32);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // call at a rising edge; returns at a rising edge after the transfer
    task automatic send_sample(input chan_t ch, input sample_t smp);
        int gap;
        sample_if.valid   <= 1'b1;
        sample_if.channel <= ch;
        sample_if.sample  <= smp;
        @(posedge clk);
        while (!sample_if.ready)
        begin
            @(posedge clk);
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic test_out_of_range();
        send_sample(chan_t'(4), sample_t'(-32768));
        send_sample(chan_t'(5), sample_t'(32767));
        send_sample(chan_t'(6), sample_t'(0));
        send_sample(chan_t'(7), sample_t'(-1));
    endtask

    task automatic test_full_scale();
        send_sample(chan_t'(0), sample_t'(32767));
        send_sample(chan_t'(0), sample_t'(32767));
        send_sample(chan_t'(0), sample_t'(32767));
        send_sample(chan_t'(0), sample_t'(32767));
        send_sample(chan_t'(0), sample_t'(-32768));
        send_sample(chan_t'(1), sample_t'(-32768));
        send_sample(chan_t'(1), sample_t'(-32768));
        send_sample(chan_t'(1), sample_t'(32767));
        send_sample(chan_t'(1), sample_t'(-1));
    endtask

    // negative sums must round toward zero
    task automatic test_truncation();
        send_sample(chan_t'(2), sample_t'(0));
        send_sample(chan_t'(2), sample_t'(-3));
        send_sample(chan_t'(2), sample_t'(3));
        send_sample(chan_t'(2), sample_t'(-7));
        send_sample(chan_t'(2), sample_t'(9));
    endtask

    task automatic test_window_wrap();
        send_sample(chan_t'(3), sample_t'(1));
        for (int i = 1; i <= WINDOW + 1; i++)
        begin
            send_sample(chan_t'(3), sample_t'(i * 100));
        end
    endtask

    task automatic test_random(input int count, input bit idle, input bit stall);
        chan_t ch;
        tx_idle_en  = idle;
        rx_stall_en = stall;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                ch = chan_t'($urandom_range(0, CHANNELS - 1));
            end
            else
            begin
                ch = chan_t'($urandom_range(CHANNELS, (1 << CHANNEL_BITS) - 1));
            end
            send_sample(ch, pick_sample());
        end
    endtask

    initial
    begin
        error_count        = 0;
        in_transfers       = 0;
        results_checked    = 0;
        out_of_range_count = 0;
        priming_count      = 0;
        tx_idle_en         = 1'b1;
        rx_stall_en        = 1'b1;
        for (int c = 0; c < CHANNELS; c++)
        begin
            hist_sum[c]    = '0;
            hist_pos[c]    = 0;
            hist_primed[c] = 1'b0;
            for (int j = 0; j < WINDOW; j++)
            begin
                hist_window[c][j] = '0;
            end
        end
        rst_n             <= 1'b0;
        sample_if.valid   <= 1'b0;
        sample_if.channel <= '0;
        sample_if.sample  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_out_of_range();
        test_full_scale();
        test_truncation();
        test_window_wrap();
        test_random(275, 1'b1, 1'b1);
        test_random(275, 1'b0, 1'b0);
        test_random(275, 1'b1, 1'b0);
        test_random(275, 1'b0, 1'b1);
        sample_if.valid <= 1'b0;

        while (expected_averages.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("%0d input transfers, %0d results checked, %0d mismatches",
                 in_transfers, results_checked, error_count);
        $display("%0d out-of-range passes, %0d channel primings, idle and stall mixes",
                 out_of_range_count, priming_count);
        if (error_count == 0)
        begin
            $display("tb_multichannel_moving_average: PASS");
        end
        else
        begin
            $display("tb_multichannel_moving_average: FAIL");
        end
        $finish;
    end

endmodule
